/* hw/rtl/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the timed position queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DL_W                = 48;
    localparam int DELAY_W             = 32;
    localparam int COORD_W             = 16;
    localparam int CNT_OUT_W           = 5;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // one stored entry
    typedef struct packed {
        logic        [DL_W-1:0]    deadline;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/tpq_store.sv */
// ----------------------------------------------------------------------------
// tpq_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_store
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int AW          = $clog2(QUEUE_DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t mem [QUEUE_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tpq_ctrl.sv */
// ----------------------------------------------------------------------------
// tpq_ctrl
// Sequencer: sorted insert by shifting entries one slot a step, and head
// pops over a circular buffer; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_ctrl
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int AW          = $clog2(QUEUE_DEPTH),
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      req_type,
    input  wire logic [DL_W-1:0]           now_us,
    input  wire logic signed [COORD_W-1:0] pos_x,
    input  wire logic signed [COORD_W-1:0] pos_y,
    input  wire logic [DELAY_W-1:0]        delay_us,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           status,
    output logic                           pos_valid,
    output logic signed [COORD_W-1:0]      cur_x,
    output logic signed [COORD_W-1:0]      cur_y,
    output logic [CNT_OUT_W-1:0]           removed_count,
    output logic [CNT_OUT_W-1:0]           occupancy,
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output entry_t                         wr_data,
    output logic                           rd_en,
    output logic [AW-1:0]                  rd_addr,
    input  wire entry_t                    rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_UPD_RD,
        ST_UPD_CMP,
        ST_FINISH
    } state_t;

    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

    state_t                     state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              slot_reg, slot_next;
    logic [CW-1:0]              left_reg, left_next;
    logic [DL_W-1:0]            dl_reg, dl_next;
    logic signed [COORD_W-1:0]  nx_reg, nx_next;
    logic signed [COORD_W-1:0]  ny_reg, ny_next;
    logic [CW-1:0]              removed_reg, removed_next;
    logic signed [COORD_W-1:0]  lx_reg, lx_next;
    logic signed [COORD_W-1:0]  ly_reg, ly_next;
    logic                       full_reg, full_next;
    logic                       rep_reg, rep_next;
    logic                       ins_reg, ins_next;
    logic                       ov_reg, ov_next;
    logic                       st_reg, st_next;
    logic                       pv_reg, pv_next;
    logic signed [COORD_W-1:0]  cx_reg, cx_next;
    logic signed [COORD_W-1:0]  cy_reg, cy_next;
    logic [CW-1:0]              rc_reg, rc_next;
    logic [CW-1:0]              oc_reg, oc_next;

    logic [DL_W:0]   dl_sum;
    logic [AW:0]     tail_sum;
    logic [AW-1:0]   tail_addr;
    logic [AW-1:0]   slot_prev;
    logic [AW-1:0]   head_succ;

    // saturating deadline and circular address arithmetic
    always_comb
    begin
        dl_sum    = {1'b0, now_us} + (DL_W+1)'(delay_us);
        tail_sum  = {1'b0, head_reg} + (AW+1)'(count_reg);
        tail_addr = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : tail_sum[AW-1:0];
        slot_prev = (slot_reg == '0) ? LAST_ADDR : slot_reg - 1'b1;
        head_succ = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
    end

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        left_next    = left_reg;
        dl_next      = dl_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        removed_next = removed_reg;
        lx_next      = lx_reg;
        ly_next      = ly_reg;
        full_next    = full_reg;
        rep_next     = rep_reg;
        ins_next     = ins_reg;
        ov_next      = ov_reg;
        st_next      = st_reg;
        pv_next      = pv_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        rc_next      = rc_reg;
        oc_next      = oc_reg;
        wr_en        = 1'b0;
        wr_addr      = slot_reg;
        wr_data      = '{deadline: dl_reg, x: nx_reg, y: ny_reg};
        rd_en        = 1'b0;
        rd_addr      = head_reg;

        // result beat taken
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dl_next      = dl_sum[DL_W] ? '1 : dl_sum[DL_W-1:0];
                    nx_next      = pos_x;
                    ny_next      = pos_y;
                    removed_next = '0;
                    rep_next     = 1'b0;
                    full_next    = 1'b0;
                    if (req_type == REQ_INSERT)
                    begin
                        ins_next = 1'b1;
                        if (count_reg >= DEPTH_CNT)
                        begin
                            full_next  = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            slot_next  = tail_addr;
                            left_next  = count_reg;
                            state_next = ST_INS_RD;
                        end
                    end
                    else
                    begin
                        ins_next   = 1'b0;
                        dl_next    = now_us;
                        state_next = ST_UPD_RD;
                    end
                end
            end

            ST_INS_RD:
            begin
                if (left_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_prev;
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data.deadline > dl_reg)
                begin
                    // move the later entry up one slot
                    wr_data    = rd_data;
                    slot_next  = slot_prev;
                    left_next  = left_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_FINISH;
                end
            end

            ST_UPD_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = ST_UPD_CMP;
            end

            ST_UPD_CMP:
            begin
                if (count_reg != '0 && rd_data.deadline < dl_reg)
                begin
                    // pop the head
                    lx_next      = rd_data.x;
                    ly_next      = rd_data.y;
                    head_next    = head_succ;
                    count_next   = count_reg - 1'b1;
                    removed_next = removed_reg + 1'b1;
                    state_next   = ST_UPD_RD;
                end
                else
                begin
                    // an equal successor suppresses the report
                    rep_next   = (removed_reg != '0) &&
                                 (count_reg == '0 || rd_data.deadline != dl_reg);
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    st_next    = full_reg;
                    pv_next    = !ins_reg && rep_reg;
                    cx_next    = (!ins_reg && rep_reg) ? lx_reg : '0;
                    cy_next    = (!ins_reg && rep_reg) ? ly_reg : '0;
                    rc_next    = ins_reg ? '0 : removed_reg;
                    oc_next    = count_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            slot_reg    <= '0;
            left_reg    <= '0;
            dl_reg      <= '0;
            nx_reg      <= '0;
            ny_reg      <= '0;
            removed_reg <= '0;
            lx_reg      <= '0;
            ly_reg      <= '0;
            full_reg    <= 1'b0;
            rep_reg     <= 1'b0;
            ins_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            st_reg      <= 1'b0;
            pv_reg      <= 1'b0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            rc_reg      <= '0;
            oc_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            slot_reg    <= slot_next;
            left_reg    <= left_next;
            dl_reg      <= dl_next;
            nx_reg      <= nx_next;
            ny_reg      <= ny_next;
            removed_reg <= removed_next;
            lx_reg      <= lx_next;
            ly_reg      <= ly_next;
            full_reg    <= full_next;
            rep_reg     <= rep_next;
            ins_reg     <= ins_next;
            ov_reg      <= ov_next;
            st_reg      <= st_next;
            pv_reg      <= pv_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            rc_reg      <= rc_next;
            oc_reg      <= oc_next;
        end
    end

    // ports
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign pos_valid     = pv_reg;
    assign cur_x         = cx_reg;
    assign cur_y         = cy_reg;
    assign removed_count = CNT_OUT_W'(rc_reg);
    assign occupancy     = CNT_OUT_W'(oc_reg);

endmodule

`default_nettype wire

/* hw/rtl/timed_position_queue_top.sv */
// ----------------------------------------------------------------------------
// timed_position_queue_top
// Deadline-ordered queue of (x,y) positions in a circular entry memory.
// ----------------------------------------------------------------------------
// One result beat per input beat. An insert stores now_us + delay_us
// (saturated to 48 bits) after every entry with an earlier or equal deadline;
// each held entry with a later deadline is shifted up one slot, and each
// shift is a read and a write back through the one read and one write port
// of the entry memory. A full queue drops the insert with status set. An
// update pops the head entries whose deadline is earlier than now_us, one
// memory read per examined head. The finishing state of an item waits for
// the output register to be free, so a result that still waits adds its
// stall. The input is taken again while the last result still waits in the
// output register. No clearing pass after reset.
`default_nettype none

module timed_position_queue_top
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      req_type,
    input  wire logic [DL_W-1:0]           now_us,
    input  wire logic signed [COORD_W-1:0] pos_x,
    input  wire logic signed [COORD_W-1:0] pos_y,
    input  wire logic [DELAY_W-1:0]        delay_us,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           status,
    output logic                           pos_valid,
    output logic signed [COORD_W-1:0]      cur_x,
    output logic signed [COORD_W-1:0]      cur_y,
    output logic [CNT_OUT_W-1:0]           removed_count,
    output logic [CNT_OUT_W-1:0]           occupancy
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    // sequencer
    tpq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .now_us        (now_us),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .delay_us      (delay_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .pos_valid     (pos_valid),
        .cur_x         (cur_x),
        .cur_y         (cur_y),
        .removed_count (removed_count),
        .occupancy     (occupancy),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // entry memory
    tpq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

/* tb/tb_timed_position_queue_top.sv */
// ----------------------------------------------------------------------------
// tb_timed_position_queue_top
// Self-checking testbench of the timed position queue: directed and random
// inserts and updates, predicted in-bench and compared beat by beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timed_position_queue_top;
    import tpq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};

    // expected result of one item
    typedef struct packed {
        logic                      status;
        logic                      pos_valid;
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic [CNT_OUT_W-1:0]      removed_count;
        logic [CNT_OUT_W-1:0]      occupancy;
    } qresult_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic req_type;
    logic [DL_W-1:0] now_us;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [DELAY_W-1:0] delay_us;
    logic out_valid;
    logic out_ready;
    logic status;
    logic pos_valid;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic [CNT_OUT_W-1:0] removed_count;
    logic [CNT_OUT_W-1:0] occupancy;

    // predictor state
    entry_t   shadow_q[$];
    qresult_t expected_q[$];
    int       mismatches;
    int       results_seen;
    int       inserts_sent;
    int       updates_sent;
    int       reports_seen;
    longint   cycles;
    int       hold_off;
    int       rx_wait;
    logic [DL_W-1:0] sim_now;

    timed_position_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // model one item and return its expected result
    function automatic qresult_t predict_item(logic rt, logic [DL_W-1:0] t,
                                              logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y,
                                              logic [DELAY_W-1:0] d);
        qresult_t r;
        entry_t   e;
        logic [DL_W:0] sum;
        int pos;
        r = '0;
        if (rt == REQ_INSERT)
        begin
            if (shadow_q.size() >= DEPTH)
                r.status = 1'b1;
            else
            begin
                sum = {1'b0, t} + (DL_W+1)'(d);
                e.deadline = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];
                e.x = x;
                e.y = y;
                pos = 0;
                while (pos < shadow_q.size() && shadow_q[pos].deadline <= e.deadline)
                    pos++;
                shadow_q.insert(pos, e);
            end
        end
        else
        begin
            while (shadow_q.size() > 0 && shadow_q[0].deadline < t)
            begin
                if (shadow_q.size() == 1 || shadow_q[1].deadline > t)
                begin
                    r.pos_valid = 1'b1;
                    r.cur_x = shadow_q[0].x;
                    r.cur_y = shadow_q[0].y;
                end
                void'(shadow_q.pop_front());
                r.removed_count++;
            end
        end
        r.occupancy = CNT_OUT_W'(shadow_q.size());
        return r;
    endfunction

    // send one beat after a random gap; valid stays up between beats
    // that follow with no gap
    task automatic send_item(logic rt, logic [DL_W-1:0] t,
                             logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y,
                             logic [DELAY_W-1:0] d, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        now_us   <= t;
        pos_x    <= x;
        pos_y    <= y;
        delay_us <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_q.push_back(predict_item(rt, t, x, y, d));
        if (rt == REQ_INSERT) inserts_sent++;
        else updates_sent++;
    endtask

    task automatic send_insert(logic [DL_W-1:0] t, logic [DELAY_W-1:0] d, bit no_gap = 0);
        send_item(REQ_INSERT, t, COORD_W'($urandom), COORD_W'($urandom), d, no_gap);
    endtask

    task automatic send_update(logic [DL_W-1:0] t);
        send_item(REQ_UPDATE, t, COORD_W'($urandom), COORD_W'($urandom), $urandom);
    endtask

    // drop valid, then wait for the queue of expectations to drain
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // receiver: a random wait before each beat plus an optional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end
        else if (rx_wait > 0)
        begin
            out_ready <= 1'b0;
            rx_wait   <= rx_wait - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        qresult_t got;
        qresult_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {status, pos_valid, cur_x, cur_y, removed_count, occupancy};
            results_seen++;
            rx_wait = $urandom_range(0, 7);
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.pos_valid) reports_seen++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at beat %0d: expected %p actual %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    // extremes, overflow, full queue, empty update, equal deadlines
    task automatic test_directed();
        send_update(0);
        send_update(DL_MAX);
        send_item(REQ_INSERT, DL_MAX, 16'sh7fff, -16'sh8000, 32'hffff_ffff);
        send_item(REQ_INSERT, 0, -16'sh8000, 16'sh7fff, 0);
        send_item(REQ_INSERT, 100, 16'sh0001, -16'sh0001, 0);
        send_item(REQ_INSERT, 100, 16'sh0002, 16'sh0002, 0);
        send_update(100);
        send_update(101);
        send_update(DL_MAX);
        for (int i = 0; i < DEPTH + 2; i++)
            send_insert(1000, $urandom_range(0, 3));
        send_update(1002);
        send_update(DL_MAX);
        send_update(DL_MAX);
        wait_drained();
    endtask

    // random traffic with a moving clock of game time
    task automatic test_random(int n);
        int k;
        sim_now = 0;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 55)
                send_insert(sim_now, $urandom_range(0, 40));
            else if (k < 60)
                send_insert(DL_W'($urandom), $urandom);
            else if (k < 63)
                send_insert(DL_W'({$urandom, $urandom}) | (DL_MAX - 32'hffff_ffff),
                            $urandom);
            else if (k < 95)
            begin
                sim_now = sim_now + DL_W'($urandom_range(0, 15));
                send_update(sim_now);
            end
            else
                send_update(DL_W'({$urandom, $urandom}));
            if (shadow_q.size() == 0 && $urandom_range(0, 9) == 0)
                sim_now = DL_W'({$urandom, $urandom});
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps going
    task automatic test_backpressure();
        hold_off = 400;
        for (int i = 0; i < 40; i++)
            send_insert(5000, $urandom_range(0, 20), 1);
        send_update(5030);
        wait_drained();
    endtask

    initial
    begin
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        inserts_sent = 0;
        updates_sent = 0;
        reports_seen = 0;
        hold_off = 0;
        rx_wait = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_INSERT;
        now_us = '0;
        pos_x = '0;
        pos_y = '0;
        delay_us = '0;
        out_ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random(1500);

        if (expected_q.size() != 0)
        begin
            mismatches += expected_q.size();
            $display("%0d results never arrived", expected_q.size());
        end
        $display("covered %0d inserts and %0d updates, %0d reported positions",
                 inserts_sent, updates_sent, reports_seen);
        $display("%0d result beats checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tpq_pkg.sv
hw/rtl/tpq_store.sv
hw/rtl/tpq_ctrl.sv
hw/rtl/timed_position_queue_top.sv
tb/tb_timed_position_queue_top.sv
